// ===== rtl/core/frsp_pkg.sv =====
`timescale 1ns / 1ps
// frsp_pkg: shared types and constants of the fasta residue stream parser
// no dependencies

package frsp_pkg;

   // character codes the parser looks for
   localparam logic [7:0] CHAR_HEADER   = 8'h3E; // '>'
   localparam logic [7:0] CHAR_HASH     = 8'h23; // '#'
   localparam logic [7:0] CHAR_BANG     = 8'h21; // '!'
   localparam logic [7:0] CHAR_DASH     = 8'h2D; // '-'
   localparam logic [7:0] CHAR_STAR     = 8'h2A; // '*'
   localparam logic [7:0] CHAR_SEMI     = 8'h3B; // ';'
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_VTAB     = 8'h0B;
   localparam logic [7:0] CHAR_FF       = 8'h0C;
   localparam logic [7:0] CASE_MASK     = 8'hDF;

   // configuration register indexes
   localparam logic [1:0] CSR_MARK_LOWERCASE = 2'd0;
   localparam logic [1:0] CSR_PARSE_GAPS     = 2'd1;
   localparam logic [1:0] CSR_SKIP_DATA      = 2'd2;

   typedef enum logic [2:0] {
      KIND_RESIDUE  = 3'd0,
      KIND_GAP      = 3'd1,
      KIND_INTERVAL = 3'd2,
      KIND_RECORD   = 3'd3,
      KIND_HEADER   = 3'd4,
      KIND_INVALID  = 3'd5,
      KIND_NOHEADER = 3'd6,
      KIND_DONE     = 3'd7
   } kind_type;

   typedef enum logic [4:0] {
      MODE_START   = 5'b00001,
      MODE_HEADER  = 5'b00010,
      MODE_COMMENT = 5'b00100,
      MODE_DATA    = 5'b01000,
      MODE_SKIP    = 5'b10000
   } line_mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  residue;
      logic [31:0] interval_start;
      logic [31:0] interval_end;
      logic [31:0] record_index;
      logic        last;
   } rsp_word_type;

endpackage

// ===== rtl/core/fasta_residue_stream_parser_top.sv =====
`timescale 1ns / 1ps
// fasta_residue_stream_parser_top: byte-wise fasta parser with result queue
// depends on frsp_pkg

// Takes a FASTA text one byte per word on the req_ stream and reports what
// each byte means on the rsp_ stream. The first byte of a line sets its kind:
// '>' opens a header (record start word, then every header byte passed
// through), '#' or '!' a comment, a line end an empty line, anything else a
// data line. Data letters come out upper-cased; '-' is a gap (parse_gaps) or
// a residue, '*' a residue, ';' drops the rest of its line, white space is
// dropped and anything else is reported as invalid. With mark_lowercase set,
// lower-case runs are reported as [start, end) residue intervals. Data before
// any header gives a no-header error and the block then ignores bytes until
// the end-of-stream word (req_tuser = 1), which closes an open run, reports
// done and makes the parser ready for a new stream (record count kept).
// Rate: each byte is decoded in the cycle it is accepted; its result words
// (none, one or two) go into a four-word output queue and a new byte is
// taken every cycle while the queue has room for two. If rsp_ never stalls,
// bytes giving one word stream at one per cycle; a byte closing a lower-case
// run (upper-case letter, record start, end of stream) gives two and can hold
// the stream when the queue fills. The user writes configuration through csr_
// only while the stream is idle (not enforced); no clearing needed after reset.

module fasta_residue_stream_parser_top
   import frsp_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // byte_in
   input  logic          req_tuser,   // action: 0 file byte, 1 end of stream
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // residue, interval_start, interval_end,
                                      // record_index
   output logic [2:0]    rsp_tuser,   // kind
   output logic          rsp_tlast,   // last word caused by this byte
   // configuration write port
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic          csr_wdata
);

   localparam int QUEUE_DEPTH = 4;

   // configuration
   logic mark_lowercase_ff, parse_gaps_ff, skip_data_ff;

   // parser state
   line_mode_type             line_mode_ff, line_mode_in;
   logic                      have_record_ff, have_record_in;
   logic                      halted_ff, halted_in;
   logic                      was_lower_ff, was_lower_in;
   logic [POSITION_BITS-1:0]  position_ff, position_in;
   logic [POSITION_BITS-1:0]  run_start_ff, run_start_in;
   logic [31:0]               record_count_ff, record_count_in;

   // result queue
   rsp_word_type queue_ff [QUEUE_DEPTH];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff, count_in;

   // decode outputs
   rsp_word_type slot_c [2];
   logic [1:0]   n_c;
   logic         accept, pop;
   logic [31:0]  position_lo, run_start_lo;

   // interval fields carry the low 32 bits of a position
   if (POSITION_BITS >= 32) begin : g_pos_wide
      assign position_lo  = position_ff[31:0];
      assign run_start_lo = run_start_ff[31:0];
   end else begin : g_pos_narrow
      assign position_lo  = {{(32-POSITION_BITS){1'b0}}, position_ff};
      assign run_start_lo = {{(32-POSITION_BITS){1'b0}}, run_start_ff};
   end

   assign req_tready = (count_ff <= 3'd2);
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      logic [7:0]   b;
      logic         upper, lower, white, do_data;
      rsp_word_type w;
      line_mode_in    = line_mode_ff;
      have_record_in  = have_record_ff;
      halted_in       = halted_ff;
      was_lower_in    = was_lower_ff;
      position_in     = position_ff;
      run_start_in    = run_start_ff;
      record_count_in = record_count_ff;
      n_c             = 2'd0;
      slot_c[0]       = '0;
      slot_c[1]       = '0;
      b       = req_tdata;
      upper   = (b >= 8'h41) && (b <= 8'h5A);
      lower   = (b >= 8'h61) && (b <= 8'h7A);
      white   = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VTAB) ||
                (b == CHAR_FF);
      do_data = 1'b0;
      w       = '0;

      if (req_tuser) begin
         // end of stream: close an open run, then done
         if (have_record_ff && was_lower_ff) begin
            w                = '0;
            w.kind           = KIND_INTERVAL;
            w.interval_start = run_start_lo;
            w.interval_end   = position_lo;
            w.record_index   = record_count_ff;
            slot_c[n_c[0]]   = w;
            n_c              = n_c + 2'd1;
         end
         w              = '0;
         w.kind         = KIND_DONE;
         w.record_index = record_count_ff;
         slot_c[n_c[0]] = w;
         n_c            = n_c + 2'd1;
         line_mode_in   = MODE_START;
         have_record_in = 1'b0;
         halted_in      = 1'b0;
         was_lower_in   = 1'b0;
         position_in    = '0;
         run_start_in   = '0;
      end else if (halted_ff) begin
         // bytes ignored until end of stream
      end else if ((b == CHAR_LF) || (b == CHAR_CR)) begin
         line_mode_in = MODE_START;
      end else begin
         case (line_mode_ff)
            MODE_START: begin
               if (b == CHAR_HEADER) begin
                  if (have_record_ff && was_lower_ff) begin
                     w                = '0;
                     w.kind           = KIND_INTERVAL;
                     w.interval_start = run_start_lo;
                     w.interval_end   = position_lo;
                     w.record_index   = record_count_ff;
                     slot_c[n_c[0]]   = w;
                     n_c              = n_c + 2'd1;
                  end
                  record_count_in = record_count_ff + 32'd1;
                  have_record_in  = 1'b1;
                  was_lower_in    = 1'b0;
                  position_in     = '0;
                  run_start_in    = '0;
                  w               = '0;
                  w.kind          = KIND_RECORD;
                  w.record_index  = record_count_in;
                  slot_c[n_c[0]]  = w;
                  n_c             = n_c + 2'd1;
                  line_mode_in    = MODE_HEADER;
               end else if ((b == CHAR_HASH) || (b == CHAR_BANG)) begin
                  line_mode_in = MODE_COMMENT;
               end else if (!have_record_ff) begin
                  halted_in      = 1'b1;
                  w              = '0;
                  w.kind         = KIND_NOHEADER;
                  w.residue      = b;
                  w.record_index = record_count_ff;
                  slot_c[0]      = w;
                  n_c            = 2'd1;
                  line_mode_in   = MODE_SKIP;
               end else if (skip_data_ff) begin
                  line_mode_in = MODE_SKIP;
               end else begin
                  line_mode_in = MODE_DATA;
                  do_data      = 1'b1;
               end
            end
            MODE_HEADER: begin
               w              = '0;
               w.kind         = KIND_HEADER;
               w.residue      = b;
               w.record_index = record_count_ff;
               slot_c[0]      = w;
               n_c            = 2'd1;
            end
            MODE_DATA: begin
               do_data = 1'b1;
            end
            default: begin
               // comment and skipped lines give nothing
            end
         endcase

         if (do_data) begin
            w              = '0;
            w.record_index = record_count_ff;
            if (upper || lower) begin
               if (mark_lowercase_ff) begin
                  if (lower && !was_lower_ff) begin
                     run_start_in = position_ff;
                  end else if (!lower && was_lower_ff) begin
                     slot_c[0].kind           = KIND_INTERVAL;
                     slot_c[0].interval_start = run_start_lo;
                     slot_c[0].interval_end   = position_lo;
                     slot_c[0].record_index   = record_count_ff;
                     n_c                      = 2'd1;
                  end
                  was_lower_in = lower;
                  position_in  = position_ff + {{(POSITION_BITS-1){1'b0}}, 1'b1};
               end
               w.kind         = KIND_RESIDUE;
               w.residue      = b & CASE_MASK;
               slot_c[n_c[0]] = w;
               n_c            = n_c + 2'd1;
            end else if ((b == CHAR_DASH) && parse_gaps_ff) begin
               w.kind    = KIND_GAP;
               w.residue = b;
               slot_c[0] = w;
               n_c       = 2'd1;
            end else if ((b == CHAR_DASH) || (b == CHAR_STAR)) begin
               w.kind    = KIND_RESIDUE;
               w.residue = b;
               slot_c[0] = w;
               n_c       = 2'd1;
            end else if (b == CHAR_SEMI) begin
               line_mode_in = MODE_SKIP;
            end else if (white) begin
               // dropped
            end else begin
               w.kind    = KIND_INVALID;
               w.residue = b;
               slot_c[0] = w;
               n_c       = 2'd1;
            end
         end
      end

      // mark the final word of this byte
      if (n_c == 2'd2) begin
         slot_c[1].last = 1'b1;
      end else if (n_c == 2'd1) begin
         slot_c[0].last = 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_lowercase_ff <= 1'b0;
         parse_gaps_ff     <= 1'b0;
         skip_data_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MARK_LOWERCASE: mark_lowercase_ff <= csr_wdata;
            CSR_PARSE_GAPS:     parse_gaps_ff     <= csr_wdata;
            CSR_SKIP_DATA:      skip_data_ff      <= csr_wdata;
            default: begin
               // unmapped index, write ignored
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff    <= MODE_START;
         have_record_ff  <= 1'b0;
         halted_ff       <= 1'b0;
         was_lower_ff    <= 1'b0;
         position_ff     <= '0;
         run_start_ff    <= '0;
         record_count_ff <= '0;
      end else if (accept) begin
         line_mode_ff    <= line_mode_in;
         have_record_ff  <= have_record_in;
         halted_ff       <= halted_in;
         was_lower_ff    <= was_lower_in;
         position_ff     <= position_in;
         run_start_ff    <= run_start_in;
         record_count_ff <= record_count_in;
      end
   end

   // result queue, up to two pushes and one pop a cycle
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_in + {1'b0, n_c};
      end
      if (pop) begin
         count_in = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + n_c;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (n_c != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= slot_c[0];
      end
      if (accept && (n_c == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= slot_c[1];
      end
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {queue_ff[rd_ptr_ff].record_index,
                        queue_ff[rd_ptr_ff].interval_end,
                        queue_ff[rd_ptr_ff].interval_start,
                        queue_ff[rd_ptr_ff].residue};

endmodule

// ===== test/tb_fasta_residue_stream_parser_top.sv =====
`timescale 1ns / 1ps
// tb_fasta_residue_stream_parser_top: self-checking bench for the fasta residue parser
// predicts every result word from the byte stream and checks it against the rsp_ stream
// depends on frsp_pkg and fasta_residue_stream_parser_top

module tb_fasta_residue_stream_parser_top
   import frsp_pkg::*;
();

   localparam int POS_BITS       = 32;
   localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake before giving up
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_BYTES    = 36;    // minimum acted-on bytes per random phase
   localparam int DRAIN_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 4;

   // ------------------------------------------------------------------
   // scoreboard: its own copy of the parser state and of the registers,
   // a queue of result words still to come from the block
   // ------------------------------------------------------------------
   class residue_scoreboard;
      rsp_word_type        expected_words[$];
      rsp_word_type        step_words[$];
      int unsigned         errors;
      bit                  mark_lower, gaps_on, skip_data;
      line_mode_type       line_mode;
      bit                  have_record, halted, was_lower;
      logic [POS_BITS-1:0] residue_pos, run_start;
      logic [31:0]         record_count;

      function new();
         errors       = 0;
         mark_lower   = 1'b0;
         gaps_on      = 1'b0;
         skip_data    = 1'b0;
         line_mode    = MODE_START;
         have_record  = 1'b0;
         halted       = 1'b0;
         was_lower    = 1'b0;
         residue_pos  = '0;
         run_start    = '0;
         record_count = '0;
      endfunction

      function void set_config(input bit m, input bit g, input bit s);
         mark_lower = m;
         gaps_on    = g;
         skip_data  = s;
      endfunction

      function void push_result(input kind_type k, input logic [7:0] r,
                                input logic [POS_BITS-1:0] s,
                                input logic [POS_BITS-1:0] e);
         rsp_word_type w;
         w.kind           = k;
         w.residue        = r;
         w.interval_start = s[31:0];
         w.interval_end   = e[31:0];
         w.record_index   = record_count;
         w.last           = 1'b0;
         step_words = {step_words, w};
      endfunction

      function void close_lower_run();
         if (have_record && was_lower) begin
            push_result(KIND_INTERVAL, 8'h00, run_start, residue_pos);
         end
         was_lower = 1'b0;
      endfunction

      function void decode_data_byte(input logic [7:0] b);
         bit upper, lower;
         upper = (b >= "A" && b <= "Z");
         lower = (b >= "a" && b <= "z");
         if (upper || lower) begin
            if (mark_lower) begin
               if (lower && !was_lower) begin
                  run_start = residue_pos;
               end else if (!lower && was_lower) begin
                  push_result(KIND_INTERVAL, 8'h00, run_start, residue_pos);
               end
               was_lower   = lower;
               residue_pos = residue_pos + POS_BITS'(1);
            end
            push_result(KIND_RESIDUE, lower ? (b & CASE_MASK) : b, '0, '0);
         end else if (b == CHAR_DASH && gaps_on) begin
            push_result(KIND_GAP, b, '0, '0);
         end else if (b == CHAR_DASH || b == CHAR_STAR) begin
            push_result(KIND_RESIDUE, b, '0, '0);
         end else if (b == CHAR_SEMI) begin
            line_mode = MODE_SKIP;
         end else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VTAB || b == CHAR_FF) begin
            // white space gives nothing
         end else begin
            push_result(KIND_INVALID, b, '0, '0);
         end
      endfunction

      // one accepted input word; returns 0 when the parser is halted and drops it
      function bit note_word(input bit end_of_stream, input logic [7:0] b);
         bit acted;
         acted = 1'b1;
         step_words.delete();
         if (end_of_stream) begin
            close_lower_run();
            push_result(KIND_DONE, 8'h00, '0, '0);
            line_mode   = MODE_START;
            have_record = 1'b0;
            halted      = 1'b0;
            was_lower   = 1'b0;
            residue_pos = '0;
            run_start   = '0;
         end else if (halted) begin
            acted = 1'b0;
         end else if (b == CHAR_LF || b == CHAR_CR) begin
            line_mode = MODE_START;
         end else if (line_mode == MODE_START) begin
            if (b == CHAR_HEADER) begin
               close_lower_run();
               record_count = record_count + 32'd1;
               have_record  = 1'b1;
               residue_pos  = '0;
               run_start    = '0;
               push_result(KIND_RECORD, 8'h00, '0, '0);
               line_mode = MODE_HEADER;
            end else if (b == CHAR_HASH || b == CHAR_BANG) begin
               line_mode = MODE_COMMENT;
            end else if (!have_record) begin
               halted = 1'b1;
               push_result(KIND_NOHEADER, b, '0, '0);
               line_mode = MODE_SKIP;
            end else if (skip_data) begin
               line_mode = MODE_SKIP;
            end else begin
               line_mode = MODE_DATA;
               decode_data_byte(b);
            end
         end else if (line_mode == MODE_HEADER) begin
            push_result(KIND_HEADER, b, '0, '0);
         end else if (line_mode == MODE_DATA) begin
            decode_data_byte(b);
         end
         if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].last = 1'b1;
         end
         expected_words = {expected_words, step_words};
         return acted;
      endfunction

      function void check_word(input logic [2:0] kind_bits, input logic [103:0] data,
                               input logic last_bit);
         rsp_word_type got, want;
         got.kind           = kind_type'(kind_bits);
         got.residue        = data[7:0];
         got.interval_start = data[39:8];
         got.interval_end   = data[71:40];
         got.record_index   = data[103:72];
         got.last           = last_bit;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected word: kind %0d res %02h start %0d end %0d rec %0d last %0b",
                        got.kind, got.residue, got.interval_start, got.interval_end,
                        got.record_index, got.last);
            end
            return;
         end
         want = expected_words.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch: exp kind %0d res %02h start %0d end %0d rec %0d last %0b",
                        want.kind, want.residue, want.interval_start, want.interval_end,
                        want.record_index, want.last);
               $display("          got kind %0d res %02h start %0d end %0d rec %0d last %0b",
                        got.kind, got.residue, got.interval_start, got.interval_end,
                        got.record_index, got.last);
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------
   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;   // byte_in
   logic          req_tuser;   // action: 0 file byte, 1 end of stream
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;   // residue, interval_start, interval_end, record_index
   logic [2:0]    rsp_tuser;   // kind
   logic          rsp_tlast;
   logic          csr_we;
   logic [1:0]    csr_addr;
   logic          csr_wdata;

   residue_scoreboard sb = new();

   // idling knobs, set by the stimulus process and read by the sender and the receiver
   int unsigned tx_gap_pct;
   int unsigned rx_stall_pct;
   int unsigned bytes_taken;

   fasta_residue_stream_parser_top #(.POSITION_BITS(POS_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // driving tasks; each is entered and left just after a rising edge
   // ------------------------------------------------------------------
   task automatic hold_sender(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // offer one word, possibly after a random gap, and wait for the handshake
   task automatic send_word(input bit end_of_stream, input logic [7:0] b);
      if (tx_gap_pct > 0 && $urandom_range(99, 0) < tx_gap_pct) begin
         hold_sender($urandom_range(19, 1));
      end
      req_tvalid <= 1'b1;
      req_tuser  <= end_of_stream;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sb.note_word(end_of_stream, b)) begin
         bytes_taken++;
      end
   endtask

   // stop sending and let every expected word come back before going on
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all three registers, written back to back while the parser is idle
   task automatic apply_config(input bit m, input bit g, input bit s);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MARK_LOWERCASE;
      csr_wdata <= m;
      @(posedge clock);
      csr_addr  <= CSR_PARSE_GAPS;
      csr_wdata <= g;
      @(posedge clock);
      csr_addr  <= CSR_SKIP_DATA;
      csr_wdata <= s;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_config(m, g, s);
   endtask

   // ------------------------------------------------------------------
   // random fasta text generators
   // ------------------------------------------------------------------
   task automatic line_end();
      case ($urandom_range(3, 0))
         0: send_word(1'b0, CHAR_CR);
         1: begin
            send_word(1'b0, CHAR_CR);
            send_word(1'b0, CHAR_LF);
         end
         default: send_word(1'b0, CHAR_LF);
      endcase
   endtask

   // header or comment body: mostly printable, now and then any byte but a line end
   task automatic free_text(input logic [7:0] opener);
      int unsigned len;
      logic [7:0]  b;
      len = $urandom_range(12, 0);
      send_word(1'b0, opener);
      repeat (len) begin
         b = ($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'($urandom_range(126, 32));
         if (b != CHAR_LF && b != CHAR_CR) send_word(1'b0, b);
      end
      line_end();
   endtask

   // data line with sticky letter case so lower-case runs form
   task automatic data_line();
      int unsigned len, pick;
      bit          in_lower;
      logic [7:0]  b;
      len      = $urandom_range(24, 1);
      in_lower = 1'($urandom_range(1, 0));
      repeat (len) begin
         pick = $urandom_range(99, 0);
         if (pick < 65) begin
            if ($urandom_range(5, 0) == 0) in_lower = !in_lower;
            b = 8'("A" + $urandom_range(25, 0));
            if (in_lower) b = b | 8'h20;
         end else if (pick < 74) begin
            b = CHAR_DASH;
         end else if (pick < 79) begin
            b = CHAR_STAR;
         end else if (pick < 88) begin
            case ($urandom_range(3, 0))
               0:       b = CHAR_SPACE;
               1:       b = CHAR_TAB;
               2:       b = CHAR_VTAB;
               default: b = CHAR_FF;
            endcase
         end else if (pick < 91) begin
            b = CHAR_SEMI;
         end else begin
            b = 8'($urandom);   // mostly invalid in data, now and then a letter
         end
         if (b != CHAR_LF && b != CHAR_CR) send_word(1'b0, b);
      end
      line_end();
   endtask

   // one stream: mostly well-formed records, sometimes headless or cut short
   task automatic random_stream();
      int unsigned records, lines;
      if ($urandom_range(9, 0) == 0) data_line();   // normally halts the parser until the end word
      records = $urandom_range(4, 1);
      repeat (records) begin
         free_text(CHAR_HEADER);
         lines = $urandom_range(4, 0);
         repeat (lines) begin
            case ($urandom_range(9, 0))
               0:       free_text($urandom_range(1, 0) ? CHAR_HASH : CHAR_BANG);
               1:       line_end();
               default: data_line();
            endcase
         end
      end
      // end of stream in the middle of a line now and then
      if ($urandom_range(3, 0) == 0) send_word(1'b0, $urandom_range(1, 0) ? "q" : "Q");
      send_word(1'b1, 8'($urandom));
   endtask

   // ------------------------------------------------------------------
   // result side: random stall bursts, every accepted word checked
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (rx_stall_pct > 0 && $urandom_range(99, 0) < rx_stall_pct) begin
            stall_left = $urandom_range(19, 1);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   // watchdog: too long without any word moving on either side
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [7:0]  opening[$];
      int unsigned phase_start;
      bit          m, g, s;

      req_tvalid   <= 1'b0;
      req_tdata    <= 8'h00;
      req_tuser    <= 1'b0;
      csr_we       <= 1'b0;
      csr_addr     <= CSR_MARK_LOWERCASE;
      csr_wdata    <= 1'b0;
      reset        <= 1'b1;
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      bytes_taken  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, all tracking on
      apply_config(1'b1, 1'b1, 1'b0);
      tx_gap_pct   = 20;
      rx_stall_pct = 20;

      // data before any header: no-header error, next byte ignored, end word recovers
      send_word(1'b0, "x");
      send_word(1'b0, "A");
      send_word(1'b1, 8'hA5);

      // header with extreme bytes, a data line with a lower-case run closed by an
      // upper-case letter, gap, star and a semicolon cutting the line, an empty
      // line, both comment openers, a data line opened by white space with an
      // invalid high byte and a misplaced '>', then a new record closing the run
      opening = '{CHAR_HEADER, 8'h00, 8'hFF, CHAR_LF,
                  "a", "c", "G", CHAR_DASH, CHAR_STAR, CHAR_SEMI, "x", CHAR_LF,
                  CHAR_CR, CHAR_HASH, CHAR_CR, CHAR_BANG, CHAR_LF,
                  CHAR_SPACE, CHAR_TAB, 8'h80, "z", CHAR_HEADER, CHAR_LF, CHAR_HEADER};
      foreach (opening[i]) send_word(1'b0, opening[i]);
      send_word(1'b1, 8'h5A);
      settle();

      // random phases, each under its own register setting; the last runs
      // without idling on either side
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       {m, g, s} = 3'b000;
            1:       {m, g, s} = 3'b111;
            2:       {m, g, s} = 3'b100;
            3:       {m, g, s} = 3'b010;
            4:       {m, g, s} = 3'b101;
            default: {m, g, s} = 3'b110;
         endcase
         apply_config(m, g, s);
         phase_start = bytes_taken;
         while (bytes_taken - phase_start < PHASE_BYTES) begin
            if (phase == PHASE_COUNT - 1) begin
               tx_gap_pct   = 0;
               rx_stall_pct = 0;
            end else begin
               // stretches with no idling between busier ones
               case ($urandom_range(2, 0))
                  0:       tx_gap_pct = 0;
                  1:       tx_gap_pct = 8;
                  default: tx_gap_pct = 30;
               endcase
               case ($urandom_range(2, 0))
                  0:       rx_stall_pct = 0;
                  1:       rx_stall_pct = 8;
                  default: rx_stall_pct = 30;
               endcase
            end
            random_stream();
         end
         settle();
      end

      // drain: nothing should be left, and nothing further should turn up
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.errors += sb.expected_words.size();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/frsp_pkg.sv
rtl/core/fasta_residue_stream_parser_top.sv
test/tb_fasta_residue_stream_parser_top.sv
